// ===== hdl/jacobi_linear_solver_assert.svh =====
// ----------------------------------------------------------------------------
// Jacobi linear solver assertion macros
// Concurrent checks that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LINEAR_SOLVER_ASSERT_SVH
`define JACOBI_LINEAR_SOLVER_ASSERT_SVH
`ifndef SYNTH
`define JLS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jacobi solver check failed");
`define JLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jacobi solver check failed");
`else
`define JLS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define JLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/jls_pkg.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver package
// Sizes, codes and the controller to datapath command and status types.
// ----------------------------------------------------------------------------
package jls_pkg;

    localparam int MAX_UNKNOWNS = 16;
    localparam int VALUE_BITS   = 32;

    localparam int IDX_W      = $clog2(MAX_UNKNOWNS);
    localparam int CNT_W      = $clog2(MAX_UNKNOWNS + 1);
    localparam int COEF_DEPTH = MAX_UNKNOWNS * MAX_UNKNOWNS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int EST_AW     = IDX_W + 1;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int DATA_W     = 32;
    localparam int ITER_W     = 16;
    localparam int STAT_W     = 2;
    localparam int UC_W       = 7;
    localparam int EB_W       = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_W  = (VALUE_BITS + 1 > 33) ? VALUE_BITS + 1 : 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 62;
    localparam int QUO_W  = VALUE_BITS + 1;
    localparam int DEN_W  = 32;
    localparam int DOM_W  = 32 + CNT_W;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BOUND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_COEF  = 2'd0,
        CMD_LOAD_CONST = 2'd1,
        CMD_LOAD_GUESS = 2'd2,
        CMD_START      = 2'd3
    } t_command;

    typedef enum logic [STAT_W-1:0] {
        ST_CONVERGED    = 2'd0,
        ST_NOT_DOMINANT = 2'd1,
        ST_LIMIT        = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DOM_CLR,
        OP_DOM_ACC,
        OP_SWEEP_INIT,
        OP_ROW_LOAD,
        OP_MUL,
        OP_ACC_SUB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MUL_CONV,
        OP_CONV_CHK,
        OP_SWEEP_END,
        OP_OUT_LOAD,
        OP_OUT_ERR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              is_diag;
        logic [ITER_W-1:0] iters;
        t_status           status;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic dom_less;
        logic dom_more;
        logic sweep_done;
    } t_stat;

endpackage

// ===== hdl/jls_if.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface jls_in_if import jls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    column;
    logic signed [31:0]  value;

    modport source (output valid, command, row, column, value, input ready);
    modport sink   (input valid, command, row, column, value, output ready);
endinterface

interface jls_out_if import jls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_W-1:0]    index;
    logic signed [31:0]  solution;
    logic [ITER_W-1:0]   iterations;
    logic [STAT_W-1:0]   status;
    logic                last;

    modport source (output valid, index, solution, iterations, status, last, input ready);
    modport sink   (input valid, index, solution, iterations, status, last, output ready);
endinterface

interface jls_cfg_if import jls_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/jacobi_linear_solver.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver
// Loads a fixed point linear system, checks diagonal dominance and runs
// Jacobi sweeps until convergence or the sweep limit.
// ----------------------------------------------------------------------------
// Usage: i_cfg writes unknown_count, error_bound and iteration_limit while
// the block is idle; it is always ready. Each i_in beat carries a command:
// coefficient, constant and initial guess loads stream at one beat per cycle
// while the block is idle. A start beat holds i_in.ready low until the
// run has emitted all of its results on o_res.
// A start first scans the coefficient rows for dominance. Each sweep reads,
// multiplies and subtracts every off-diagonal product, then runs a 33 step
// radix-2 divide and a convergence multiply per row. Results follow one per
// unknown, the last one flagged. A system that is not dominant returns one
// status beat.
// Reset clears the control state and restores the register defaults; the
// coefficient, constant and estimate stores keep undefined contents until
// loaded. When the receiver stalls, the result register holds its beat and
// the sequencer waits; a start beat may be taken while the final result of
// the previous run is still waiting.
// ----------------------------------------------------------------------------
module jacobi_linear_solver import jls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jls_cfg_if.sink     i_cfg,
    jls_in_if.sink      i_in,
    jls_out_if.source   o_res
);

    t_cmd             cmd;
    t_stat            stat;
    logic             load_en;
    logic [EB_W-1:0]  error_bound;

    jls_controller u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_cfg_ready   (i_cfg.ready),
        .i_in_valid    (i_in.valid),
        .i_in_command  (i_in.command),
        .o_in_ready    (i_in.ready),
        .o_load_en     (load_en),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_cmd         (cmd),
        .i_stat        (stat),
        .o_error_bound (error_bound)
    );

    jls_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_load_en      (load_en),
        .i_load_command (i_in.command),
        .i_load_row     (i_in.row),
        .i_load_column  (i_in.column),
        .i_load_value   (i_in.value),
        .i_error_bound  (error_bound),
        .o_stat         (stat),
        .o_index        (o_res.index),
        .o_solution     (o_res.solution),
        .o_iterations   (o_res.iterations),
        .o_status       (o_res.status),
        .o_last         (o_res.last)
    );

endmodule

// ===== hdl/jls_datapath.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver datapath
// Stores, multiplier, accumulator, radix-2 divider and result register.
// ----------------------------------------------------------------------------
`include "jacobi_linear_solver_assert.svh"

module jls_datapath import jls_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_load_en,
    input  logic [CMD_W-1:0]         i_load_command,
    input  logic [ROW_W-1:0]         i_load_row,
    input  logic [ROW_W-1:0]         i_load_column,
    input  logic signed [31:0]       i_load_value,
    input  logic [EB_W-1:0]          i_error_bound,
    output t_stat                    o_stat,
    output logic [ROW_W-1:0]         o_index,
    output logic signed [31:0]       o_solution,
    output logic [ITER_W-1:0]        o_iterations,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last
);

    localparam int SUM_W = ((ACC_W > PROD_W - 16) ? ACC_W : PROD_W - 16) + 1;
    localparam logic signed [SUM_W-1:0] ACC_LIM = SUM_W'(64'sd1 <<< 60);

    logic signed [31:0]           coef_mem  [0:COEF_DEPTH-1];
    logic signed [31:0]           const_mem [0:MAX_UNKNOWNS-1];
    logic signed [VALUE_BITS-1:0] est_mem   [0:(1 << EST_AW)-1];

    logic signed [31:0]           r_coef_rd;
    logic signed [31:0]           r_const_rd;
    logic signed [VALUE_BITS-1:0] r_est_rd;
    logic                         r_bank;
    logic                         r_done;
    logic [31:0]                  r_dom_diag;
    logic [DOM_W-1:0]             r_dom_oth;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [31:0]           r_diag;
    logic signed [VALUE_BITS-1:0] r_xi;
    logic signed [VALUE_BITS-1:0] r_y;
    logic [VALUE_BITS:0]          r_d;
    logic [DEN_W-1:0]             r_den;
    logic [DEN_W-1:0]             r_rem;
    logic [QUO_W-1:0]             r_num_sh;
    logic [QUO_W-1:0]             r_quo;
    logic                         r_neg;
    logic                         r_ovf;

    logic                 in_row_ok;
    logic                 in_col_ok;
    logic [COEF_AW-1:0]   coef_wr_addr;
    logic [COEF_AW-1:0]   coef_rd_addr;
    logic [31:0]          coef_mag;
    logic [ACC_W-1:0]     acc_mag;
    logic [ACC_W-1:0]     acc_hi;
    logic [DEN_W:0]       div_t;
    logic                 div_ge;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [SUM_W-1:0] sub_sum;
    logic signed [SUM_W-1:0] sub_clamped;
    logic signed [VALUE_BITS:0] y_diff;
    logic [VALUE_BITS-1:0] y_mag;
    logic signed [63:0]   quo_signed;
    logic                 conv;

    function automatic logic signed [VALUE_BITS-1:0] sat_value(input logic signed [63:0] v);
        if (v > VAL_MAX) begin
            return VALUE_BITS'(VAL_MAX);
        end else if (v < VAL_MIN) begin
            return VALUE_BITS'(VAL_MIN);
        end
        return VALUE_BITS'(v);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [VALUE_BITS-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (w < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return w[31:0];
    endfunction

    assign in_row_ok    = {1'b0, i_load_row} < (ROW_W + 1)'(MAX_UNKNOWNS);
    assign in_col_ok    = {1'b0, i_load_column} < (ROW_W + 1)'(MAX_UNKNOWNS);
    assign coef_wr_addr = COEF_AW'(i_load_row) * COEF_AW'(MAX_UNKNOWNS) + COEF_AW'(i_load_column);
    assign coef_rd_addr = COEF_AW'(i_cmd.row) * COEF_AW'(MAX_UNKNOWNS) + COEF_AW'(i_cmd.col);

    always_ff @(posedge i_clk) begin
        if (i_load_en && in_row_ok && in_col_ok && i_load_command == CMD_LOAD_COEF) begin
            coef_mem[coef_wr_addr] <= i_load_value;
        end
        if (i_load_en && in_row_ok && i_load_command == CMD_LOAD_CONST) begin
            const_mem[IDX_W'(i_load_row)] <= i_load_value;
        end
        if (i_load_en && in_row_ok && i_load_command == CMD_LOAD_GUESS) begin
            est_mem[{r_bank, IDX_W'(i_load_row)}] <= sat_value(64'(i_load_value));
        end else if (i_cmd.op == OP_CONV_CHK) begin
            est_mem[{~r_bank, i_cmd.row}] <= r_y;
        end
        r_coef_rd  <= coef_mem[coef_rd_addr];
        r_const_rd <= const_mem[i_cmd.row];
        r_est_rd   <= est_mem[{r_bank, i_cmd.col}];
    end

    assign coef_mag = r_coef_rd[31] ? 32'(-r_coef_rd) : 32'(r_coef_rd);
    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign acc_hi   = acc_mag >> (QUO_W - 16);
    assign div_t    = {r_rem, r_num_sh[QUO_W-1]};
    assign div_ge   = div_t >= {1'b0, r_den};

    always_comb begin
        if (i_cmd.op == OP_MUL_CONV) begin
            mul_a = MUL_W'(i_error_bound);
            mul_b = MUL_W'(y_mag);
        end else begin
            mul_a = MUL_W'(r_coef_rd);
            mul_b = MUL_W'(r_est_rd);
        end
    end

    assign sub_sum = SUM_W'(r_acc) - SUM_W'(r_prod >>> 16);
    always_comb begin
        if (sub_sum > ACC_LIM) begin
            sub_clamped = ACC_LIM;
        end else if (sub_sum < -ACC_LIM) begin
            sub_clamped = -ACC_LIM;
        end else begin
            sub_clamped = sub_sum;
        end
    end

    assign y_diff     = (VALUE_BITS + 1)'(r_y) - (VALUE_BITS + 1)'(r_xi);
    assign y_mag      = r_y[VALUE_BITS-1] ? VALUE_BITS'(-r_y) : VALUE_BITS'(r_y);
    assign quo_signed = r_neg ? -$signed(64'(r_quo)) : $signed(64'(r_quo));
    assign conv       = (r_y == '0) ? (r_xi == '0)
                        : !(PROD_W'({r_d, 16'b0}) > $unsigned(r_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_done <= 1'b1;
        end else begin
            unique case (i_cmd.op)
                OP_DOM_CLR: begin
                    r_dom_diag <= '0;
                    r_dom_oth  <= '0;
                end
                OP_DOM_ACC: begin
                    if (i_cmd.is_diag) begin
                        r_dom_diag <= coef_mag;
                    end else begin
                        r_dom_oth <= r_dom_oth + DOM_W'(coef_mag);
                    end
                end
                OP_SWEEP_INIT: begin
                    r_done <= 1'b1;
                end
                OP_ROW_LOAD: begin
                    r_acc  <= ACC_W'(r_const_rd);
                    r_diag <= r_coef_rd;
                    r_xi   <= r_est_rd;
                end
                OP_MUL, OP_MUL_CONV: begin
                    r_prod <= mul_a * mul_b;
                    r_d    <= y_diff[VALUE_BITS] ? (VALUE_BITS + 1)'(-y_diff)
                                                 : (VALUE_BITS + 1)'(y_diff);
                end
                OP_ACC_SUB: begin
                    r_acc <= ACC_W'(sub_clamped);
                end
                OP_DIV_INIT: begin
                    r_den    <= r_diag[31] ? DEN_W'(-r_diag) : DEN_W'(r_diag);
                    r_neg    <= r_acc[ACC_W-1] ^ r_diag[31];
                    r_ovf    <= acc_hi >= ACC_W'(r_diag[31] ? DEN_W'(-r_diag)
                                                            : DEN_W'(r_diag));
                    r_rem    <= (acc_hi >= ACC_W'(r_diag[31] ? DEN_W'(-r_diag)
                                                             : DEN_W'(r_diag)))
                                ? '0 : DEN_W'(acc_hi);
                    r_num_sh <= {acc_mag[QUO_W-17:0], 16'b0};
                    r_quo    <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem    <= div_ge ? DEN_W'(div_t - {1'b0, r_den}) : DEN_W'(div_t);
                    r_quo    <= {r_quo[QUO_W-2:0], div_ge};
                    r_num_sh <= r_num_sh << 1;
                end
                OP_DIV_END: begin
                    if (r_diag == '0) begin
                        r_y <= r_xi;
                    end else if (r_ovf) begin
                        r_y <= r_neg ? VALUE_BITS'(VAL_MIN) : VALUE_BITS'(VAL_MAX);
                    end else begin
                        r_y <= sat_value(quo_signed);
                    end
                end
                OP_CONV_CHK: begin
                    if (!conv) begin
                        r_done <= 1'b0;
                    end
                end
                OP_SWEEP_END: begin
                    r_bank <= ~r_bank;
                    r_done <= 1'b1;
                end
                OP_OUT_LOAD: begin
                    o_index      <= ROW_W'(i_cmd.row);
                    o_solution   <= clamp32(r_est_rd);
                    o_iterations <= i_cmd.iters;
                    o_status     <= i_cmd.status;
                    o_last       <= i_cmd.last;
                end
                OP_OUT_ERR: begin
                    o_index      <= '0;
                    o_solution   <= '0;
                    o_iterations <= '0;
                    o_status     <= ST_NOT_DOMINANT;
                    o_last       <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.dom_less   = DOM_W'(r_dom_diag) < r_dom_oth;
    assign o_stat.dom_more   = DOM_W'(r_dom_diag) > r_dom_oth;
    assign o_stat.sweep_done = r_done;

    `JLS_ASSERT_IMPLY(a_div_rem_below_den, i_clk, i_rst_n,
        i_cmd.op == OP_DIV_STEP && !r_ovf, r_rem < r_den)
    `JLS_ASSERT_NEXT(a_bank_flips, i_clk, i_rst_n,
        i_cmd.op == OP_SWEEP_END, r_bank != $past(r_bank) && r_done)

endmodule

// ===== hdl/jls_controller.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver controller
// Configuration registers and the sequencer for dominance check, sweeps
// and result emission.
// ----------------------------------------------------------------------------
`include "jacobi_linear_solver_assert.svh"

module jls_controller import jls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    input  logic                  i_in_valid,
    input  logic [CMD_W-1:0]      i_in_command,
    output logic                  o_in_ready,
    output logic                  o_load_en,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_cmd                  o_cmd,
    input  t_stat                 i_stat,
    output logic [EB_W-1:0]       o_error_bound
);

    typedef enum logic [4:0] {
        S_IDLE, S_DOM_ROW, S_DOM_RD, S_DOM_ACC, S_DOM_CHK, S_SWEEP_INIT,
        S_ROW, S_ROW_LD, S_RD, S_MUL, S_SUB, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
        S_CONV_MUL, S_CONV_CHK, S_SWEEP_END, S_EMIT_RD, S_EMIT, S_ERR
    } t_state;

    t_state              r_state;
    logic [UC_W-1:0]     r_unknown_count;
    logic [EB_W-1:0]     r_error_bound;
    logic [ITER_W-1:0]   r_iteration_limit;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_i;
    logic [CNT_W-1:0]    r_j;
    logic [STEP_W-1:0]   r_step;
    logic [ITER_W-1:0]   r_limit;
    logic [ITER_W-1:0]   r_sweeps;
    t_status             r_status;
    logic                r_strict;
    logic                r_out_valid;

    logic                accept;
    logic                out_free;
    logic                i_last;
    logic [ITER_W-1:0]   n_sweeps;
    logic                n_strict;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = r_state == S_IDLE;
    assign accept        = i_in_valid && o_in_ready;
    assign o_load_en     = accept && i_in_command != CMD_START;
    assign o_out_valid   = r_out_valid;
    assign o_error_bound = r_error_bound;
    assign out_free      = !r_out_valid || i_out_ready;
    assign i_last        = r_i == r_n - CNT_W'(1);
    assign n_sweeps      = r_sweeps + ITER_W'(1);
    assign n_strict      = r_strict || i_stat.dom_more;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.row     = IDX_W'(r_i);
        o_cmd.col     = IDX_W'(r_j);
        o_cmd.is_diag = r_j == r_i;
        o_cmd.iters   = r_sweeps;
        o_cmd.status  = r_status;
        o_cmd.last    = i_last;
        unique case (r_state)
            S_DOM_ROW:    o_cmd.op = OP_DOM_CLR;
            S_DOM_ACC:    o_cmd.op = OP_DOM_ACC;
            S_SWEEP_INIT: o_cmd.op = OP_SWEEP_INIT;
            S_ROW:        o_cmd.col = IDX_W'(r_i);
            S_ROW_LD:     o_cmd.op = OP_ROW_LOAD;
            S_MUL:        o_cmd.op = OP_MUL;
            S_SUB:        o_cmd.op = OP_ACC_SUB;
            S_DIV_INIT:   o_cmd.op = OP_DIV_INIT;
            S_DIV_STEP:   o_cmd.op = OP_DIV_STEP;
            S_DIV_END:    o_cmd.op = OP_DIV_END;
            S_CONV_MUL:   o_cmd.op = OP_MUL_CONV;
            S_CONV_CHK:   o_cmd.op = OP_CONV_CHK;
            S_SWEEP_END:  o_cmd.op = OP_SWEEP_END;
            S_EMIT_RD:    o_cmd.col = IDX_W'(r_i);
            S_EMIT: begin
                o_cmd.col = IDX_W'(r_i);
                o_cmd.op  = out_free ? OP_OUT_LOAD : OP_NONE;
            end
            S_ERR:        o_cmd.op = out_free ? OP_OUT_ERR : OP_NONE;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_unknown_count   <= UC_W'(1);
            r_error_bound     <= '0;
            r_iteration_limit <= '1;
            r_n               <= CNT_W'(1);
            r_i               <= '0;
            r_j               <= '0;
            r_step            <= '0;
            r_limit           <= ITER_W'(1);
            r_sweeps          <= '0;
            r_status          <= ST_CONVERGED;
            r_strict          <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_UNKNOWN_COUNT:   r_unknown_count   <= i_cfg_data[UC_W-1:0];
                    CFG_ERROR_BOUND:     r_error_bound     <= i_cfg_data[EB_W-1:0];
                    CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[ITER_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_in_command == CMD_START) begin
                        if (r_unknown_count == '0) begin
                            r_n <= CNT_W'(1);
                        end else if (r_unknown_count > UC_W'(MAX_UNKNOWNS)) begin
                            r_n <= CNT_W'(MAX_UNKNOWNS);
                        end else begin
                            r_n <= CNT_W'(r_unknown_count);
                        end
                        r_limit  <= (r_iteration_limit == '0) ? ITER_W'(1) : r_iteration_limit;
                        r_sweeps <= '0;
                        r_i      <= '0;
                        r_strict <= 1'b0;
                        r_state  <= S_DOM_ROW;
                    end
                end
                S_DOM_ROW: begin
                    r_j     <= '0;
                    r_state <= S_DOM_RD;
                end
                S_DOM_RD: begin
                    r_state <= (r_j == r_n) ? S_DOM_CHK : S_DOM_ACC;
                end
                S_DOM_ACC: begin
                    r_j     <= r_j + CNT_W'(1);
                    r_state <= S_DOM_RD;
                end
                S_DOM_CHK: begin
                    r_strict <= n_strict;
                    if (i_stat.dom_less) begin
                        r_state <= S_ERR;
                    end else if (i_last) begin
                        r_state <= n_strict ? S_SWEEP_INIT : S_ERR;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_DOM_ROW;
                    end
                end
                S_SWEEP_INIT: begin
                    r_i     <= '0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_j     <= '0;
                    r_state <= S_ROW_LD;
                end
                S_ROW_LD: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_j == r_n) begin
                        r_state <= S_DIV_INIT;
                    end else if (r_j == r_i) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_j     <= r_j + CNT_W'(1);
                    r_state <= S_RD;
                end
                S_DIV_INIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_state <= S_CONV_MUL;
                end
                S_CONV_MUL: begin
                    r_state <= S_CONV_CHK;
                end
                S_CONV_CHK: begin
                    if (i_last) begin
                        r_state <= S_SWEEP_END;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_ROW;
                    end
                end
                S_SWEEP_END: begin
                    r_sweeps <= n_sweeps;
                    r_i      <= '0;
                    if (i_stat.sweep_done) begin
                        r_status <= ST_CONVERGED;
                        r_state  <= S_EMIT_RD;
                    end else if (n_sweeps >= r_limit) begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_EMIT_RD;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (i_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_ERR: begin
                    r_sweeps <= '0;
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `JLS_ASSERT_NEXT(a_start_blocks_input, i_clk, i_rst_n,
        accept && i_in_command == CMD_START, !o_in_ready)
    `JLS_ASSERT_IMPLY(a_load_only_when_free, i_clk, i_rst_n,
        o_cmd.op == OP_OUT_LOAD || o_cmd.op == OP_OUT_ERR, out_free)
    `JLS_ASSERT_IMPLY(a_sweeps_within_limit, i_clk, i_rst_n,
        1'b1, r_sweeps <= r_limit)

endmodule
